// ===== rtl/dhcp_option_tlv_parser_top_assert.svh =====
// Assertion macros for the DHCP options parser checker.
// No dependencies; the including module must have i_clk and i_rst_n.
`ifndef DHCP_OPTION_TLV_PARSER_TOP_ASSERT_SVH
`define DHCP_OPTION_TLV_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define DHCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included
`define DHCP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/dhcp_opt_pkg.sv =====
// Shared types and constants for the DHCP options TLV parser.
// No dependencies.
package dhcp_opt_pkg;

    // Default cap on parsed option bytes per frame
    localparam int MAX_OPTION_BYTES_DEF = 312;

    // Option codes
    localparam logic [7:0] CODE_PAD    = 8'd0;
    localparam logic [7:0] CODE_SUBNET = 8'd1;
    localparam logic [7:0] CODE_ROUTER = 8'd3;
    localparam logic [7:0] CODE_DNS    = 8'd6;
    localparam logic [7:0] CODE_LEASE  = 8'd51;
    localparam logic [7:0] CODE_MTYPE  = 8'd53;
    localparam logic [7:0] CODE_SERVER = 8'd54;
    localparam logic [7:0] CODE_RENEW  = 8'd58;
    localparam logic [7:0] CODE_REBIND = 8'd59;
    localparam logic [7:0] CODE_END    = 8'd255;

    // Minimum value lengths for a commit
    localparam logic [3:0] LEN_WORD     = 4'd4;
    localparam logic [3:0] LEN_TWO_WORD = 4'd8;

    // Input item: one options byte
    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } t_in_item;

    // Result item: extracted option values
    typedef struct packed {
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_first;
        logic [31:0] dns_second;
        logic [31:0] lease_seconds;
        logic [7:0]  message_type;
        logic [31:0] server_addr;
        logic [31:0] renew_seconds;
        logic [31:0] rebind_seconds;
    } t_out_item;

endpackage

// ===== rtl/dhcp_option_tlv_parser_top.sv =====
// DHCP options TLV parser, top level.
// Depends on dhcp_opt_pkg.
//
// Takes one byte of a DHCP options area per cycle and walks its code/length/value
// records, keeping subnet mask, router, two DNS servers, lease, renewal and
// rebind times, server identifier and message type. One result item leaves on
// the cycle after the byte flagged last_byte is taken; fields whose option was
// absent, too short or cut off read zero, and all values clear for the next frame.
// The parser state and the found values are one register stage, and the result
// sits in an output register. Bytes that are not last are taken even while a
// result waits; a last byte is held off only while the previous result is still
// stalled. Bytes beyond MAX_OPTION_BYTES are ignored.
module dhcp_option_tlv_parser_top #(
    parameter int MAX_OPTION_BYTES = dhcp_opt_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  dhcp_opt_pkg::t_in_item  i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output dhcp_opt_pkg::t_out_item o_out
);
    import dhcp_opt_pkg::*;

    localparam int FCW = $clog2(MAX_OPTION_BYTES + 1);

    // Slots of the found-value registers
    localparam int W_SUBNET = 0;
    localparam int W_ROUTER = 1;
    localparam int W_DNS1   = 2;
    localparam int W_DNS2   = 3;
    localparam int W_LEASE  = 4;
    localparam int W_SERVER = 5;
    localparam int W_RENEW  = 6;
    localparam int W_REBIND = 7;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_left, n_left;
    logic [3:0]  r_index, n_index;
    logic [63:0] r_value, n_value;
    logic [FCW-1:0] r_frame_count;
    logic [31:0] r_found [8];
    logic [31:0] n_found [8];
    logic [7:0]  r_type, n_type;
    logic        r_out_valid;
    t_out_item   r_out;

    logic accept;
    logic in_window;
    logic [7:0] left_dec;

    // Hold a last byte only while the previous result is still stalled
    assign o_in_stall  = r_out_valid && i_out_stall && i_in.last_byte;
    assign accept      = i_in_valid && !o_in_stall;
    assign in_window   = r_frame_count < FCW'(MAX_OPTION_BYTES);
    assign left_dec    = r_left - 8'd1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Advance the TLV walk by one byte and commit completed values
    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_left  = r_left;
        n_index = r_index;
        n_value = r_value;
        n_found = r_found;
        n_type  = r_type;
        if (accept && in_window) begin
            unique case (r_phase)
                PH_CODE: begin
                    if (i_in.opt_byte == CODE_END) begin
                        n_phase = PH_DONE;
                    end else if (i_in.opt_byte != CODE_PAD) begin
                        n_code  = i_in.opt_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_left  = i_in.opt_byte;
                    n_index = 4'd0;
                    // a zero-length record commits nothing
                    n_phase = (i_in.opt_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    // keep the first eight value bytes, first byte highest
                    if (r_index < LEN_TWO_WORD) begin
                        for (int k = 0; k < 8; k++) begin
                            if (r_index[2:0] == 3'(k)) begin
                                n_value[63-8*k -: 8] = i_in.opt_byte;
                            end
                        end
                        n_index = r_index + 4'd1;
                    end
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = PH_CODE;
                        case (r_code)
                            CODE_SUBNET: begin
                                if (n_index >= LEN_WORD) n_found[W_SUBNET] = n_value[63:32];
                            end
                            CODE_ROUTER: begin
                                if (n_index >= LEN_WORD) n_found[W_ROUTER] = n_value[63:32];
                            end
                            CODE_DNS: begin
                                if (n_index >= LEN_WORD) n_found[W_DNS1] = n_value[63:32];
                                if (n_index >= LEN_TWO_WORD) n_found[W_DNS2] = n_value[31:0];
                            end
                            CODE_LEASE: begin
                                if (n_index >= LEN_WORD) n_found[W_LEASE] = n_value[63:32];
                            end
                            CODE_MTYPE: begin
                                n_type = n_value[63:56];
                            end
                            CODE_SERVER: begin
                                if (n_index >= LEN_WORD) n_found[W_SERVER] = n_value[63:32];
                            end
                            CODE_RENEW: begin
                                if (n_index >= LEN_WORD) n_found[W_RENEW] = n_value[63:32];
                            end
                            CODE_REBIND: begin
                                if (n_index >= LEN_WORD) n_found[W_REBIND] = n_value[63:32];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Hold parser state; clear it at reset and after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.last_byte)) begin
            r_phase       <= PH_CODE;
            r_code        <= '0;
            r_left        <= '0;
            r_index       <= '0;
            r_frame_count <= '0;
            r_type        <= '0;
            for (int k = 0; k < 8; k++) begin
                r_found[k] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_left  <= n_left;
            r_index <= n_index;
            r_found <= n_found;
            r_type  <= n_type;
            if (accept && in_window) begin
                r_frame_count <= r_frame_count + FCW'(1);
            end
        end
    end

    // Value lanes are only read once written, so they need no clearing
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Load the result on the last byte; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.last_byte) begin
            r_out.subnet_mask    <= n_found[W_SUBNET];
            r_out.router_addr    <= n_found[W_ROUTER];
            r_out.dns_first      <= n_found[W_DNS1];
            r_out.dns_second     <= n_found[W_DNS2];
            r_out.lease_seconds  <= n_found[W_LEASE];
            r_out.message_type   <= n_type;
            r_out.server_addr    <= n_found[W_SERVER];
            r_out.renew_seconds  <= n_found[W_RENEW];
            r_out.rebind_seconds <= n_found[W_REBIND];
        end
    end

endmodule

// ===== rtl/dhcp_opt_checker.sv =====
// Port-level checker for the DHCP options TLV parser, bound to the top level.
// Depends on dhcp_opt_pkg and dhcp_option_tlv_parser_top_assert.svh.
`include "dhcp_option_tlv_parser_top_assert.svh"

module dhcp_opt_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input dhcp_opt_pkg::t_in_item  i_in,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input dhcp_opt_pkg::t_out_item o_out
);
    import dhcp_opt_pkg::*;

    logic in_take;
    logic out_held;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    // No result straight after reset
    `DHCP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A taken last byte always yields a result next cycle
    `DHCP_ASSERT(a_last_gives_result, in_take && i_in.last_byte |=> o_out_valid,
        "last byte gave no result")

    // Other bytes never invent a result
    `DHCP_ASSERT(a_no_spurious, in_take && !i_in.last_byte && !out_held |=> !o_out_valid,
        "result without a last byte")

    // Input is held off only behind a stalled result
    `DHCP_ASSERT(a_stall_cause, o_in_stall |-> out_held, "input stalled with output free")

endmodule

bind dhcp_option_tlv_parser_top dhcp_opt_checker u_dhcp_opt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
